[rtl/pedestrian_crossing_light_sequencer_macros.svh]
// Assertion macros for the pedestrian crossing light sequencer.
// Expects signals named clk and rst_n in the including module.
`ifndef PEDESTRIAN_CROSSING_LIGHT_SEQUENCER_MACROS_SVH
`define PEDESTRIAN_CROSSING_LIGHT_SEQUENCER_MACROS_SVH

// Immediate implication checked on every edge outside reset.
`define PCLS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every edge outside reset.
`define PCLS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pcls_pkg.sv]
// Shared types and constants for the pedestrian crossing light sequencer.
// No dependencies.
package pcls_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned BLINK_W   = 3;
  localparam int unsigned BLINK_REPEATS_DEF = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBER_TIME        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_TIME         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PAUSE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_PAUSE      = 3'd4;

  localparam logic [CFG_W-1:0] BLINK_HALF_PERIOD_RST = 16'd500;
  localparam logic [CFG_W-1:0] AMBER_TIME_RST        = 16'd2000;
  localparam logic [CFG_W-1:0] WALK_TIME_RST         = 16'd5000;
  localparam logic [CFG_W-1:0] REFRESH_PAUSE_RST     = 16'd100;
  localparam logic [CFG_W-1:0] SETTLE_PAUSE_RST      = 16'd100;

  // lamp masks
  localparam logic [7:0] WALK_RED_BIT  = 8'b0001_0000;
  localparam logic [7:0] WALK_GO_BIT   = 8'b0000_1000;
  localparam logic [7:0] WALK_BLUE_BIT = 8'b0000_0100;
  localparam logic [7:0] HIGH_GROUP    = 8'b1110_0000;
  localparam logic [7:0] LOW_GROUP     = 8'b0001_1100;
  localparam logic [7:0] HIGH_RED      = 8'b1000_0000;
  localparam logic [7:0] HIGH_AMBER    = 8'b0100_0000;
  localparam logic [7:0] HIGH_GREEN    = 8'b0010_0000;
  localparam logic [7:0] NORTH_GREEN   = 8'b0000_0100;

  // byte zero patterns
  localparam logic [7:0] B0_ALL_AMBER  = 8'h48;
  localparam logic [7:0] B0_NS_GREEN   = 8'h30;
  localparam logic [7:0] B0_EW_GREEN   = 8'h84;

  localparam logic [7:0] LB0_RST = 8'h84;
  localparam logic [7:0] LB1_RST = 8'h30;
  localparam logic [7:0] LB2_RST = 8'h90;

  typedef struct packed {
    logic north_walk_request;
    logic west_walk_request;
  } in_item_t;

  typedef struct packed {
    logic [7:0] light_byte_zero;
    logic [7:0] light_byte_one;
    logic [7:0] light_byte_two;
    logic       refresh_strobe;
  } out_item_t;

endpackage

[rtl/pedestrian_crossing_light_sequencer.sv]
// Top level of the pedestrian crossing light sequencer: phase FSM, countdown, lights.
// Depends on pcls_pkg and pedestrian_crossing_light_sequencer_macros.svh.
//
//  port group   dir  handshake          payload
//  in_*         in   in_valid/in_ready  pcls_pkg::in_item_t (walk requests)
//  out_*        out  out_valid/out_ready pcls_pkg::out_item_t (light bytes, strobe)
//  cfg_*        in   cfg_we             cfg_index, cfg_wdata (16 bits)
//
// One tick per cycle while in_ready is high: each accepted tick updates the phase,
// countdown and lights in one pass and lands its result in the output register.
// in_ready drops only while a result sits unread with out_ready low.
// rst_n (synchronous) restores E/W green, walk red and the register defaults.
`include "pedestrian_crossing_light_sequencer_macros.svh"

module pedestrian_crossing_light_sequencer #(
  parameter int unsigned BLINK_REPEATS = pcls_pkg::BLINK_REPEATS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pcls_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pcls_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [pcls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcls_pkg::CFG_W-1:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_BLINK_ON  = 3'd1,
    ST_BLINK_OFF = 3'd2,
    ST_AMBER     = 3'd3,
    ST_CROSS     = 3'd4,
    ST_WALK_GO   = 3'd5,
    ST_WALK_RED  = 3'd6
  } step_t;

  localparam logic [pcls_pkg::BLINK_W-1:0] REPEATS = pcls_pkg::BLINK_W'(BLINK_REPEATS);

  logic [pcls_pkg::CFG_W-1:0] blink_half_r, amber_time_r, walk_time_r;
  logic [pcls_pkg::CFG_W-1:0] refresh_pause_r, settle_pause_r;

  step_t                       step_r, step_nxt;
  logic                        west_r, west_nxt;
  logic [pcls_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [pcls_pkg::BLINK_W-1:0] blink_r, blink_nxt, blink_inc;
  logic                        north_pend_r, north_pend_nxt;
  logic                        west_pend_r, west_pend_nxt;
  logic [7:0]                  lb0_r, lb1_r, lb2_r, lb0_nxt, lb1_nxt, lb2_nxt;
  logic                        strobe;
  logic [7:0]                  wb, wb_nxt;

  // road service start request
  logic                        svc;
  logic                        svc_west;
  logic [pcls_pkg::CNT_W-1:0]  svc_wait;
  logic                        svc_green;

  logic                        out_valid_r;
  pcls_pkg::out_item_t         out_data_r;
  logic                        in_fire;

  logic [pcls_pkg::CNT_W-1:0]  rp_ext;
  logic                        cnt_busy;
  logic                        blinking;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rp_ext    = pcls_pkg::CNT_W'(refresh_pause_r);
  assign wb        = west_r ? lb2_r : lb1_r;
  assign blink_inc = blink_r + 1'b1;
  assign cnt_busy  = cnt_r > pcls_pkg::CNT_W'(1);
  assign blinking  = (step_r == ST_BLINK_ON) || (step_r == ST_BLINK_OFF);

  always_comb begin
    step_nxt       = step_r;
    west_nxt       = west_r;
    cnt_nxt        = cnt_r;
    blink_nxt      = blink_r;
    north_pend_nxt = north_pend_r;
    west_pend_nxt  = west_pend_r;
    lb0_nxt        = lb0_r;
    lb1_nxt        = lb1_r;
    lb2_nxt        = lb2_r;
    wb_nxt         = wb;
    strobe         = 1'b0;
    svc            = 1'b0;
    svc_west       = 1'b0;
    svc_wait       = '0;

    if (cnt_busy) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = '0;
      unique case (step_r)
        ST_BLINK_ON: begin
          wb_nxt   = wb | pcls_pkg::WALK_BLUE_BIT;
          strobe   = 1'b1;
          cnt_nxt  = rp_ext + pcls_pkg::CNT_W'(blink_half_r);
          step_nxt = ST_BLINK_OFF;
        end
        ST_BLINK_OFF: begin
          wb_nxt  = (wb & pcls_pkg::HIGH_GROUP) | pcls_pkg::WALK_RED_BIT;
          strobe  = 1'b1;
          cnt_nxt = rp_ext + pcls_pkg::CNT_W'(blink_half_r);
          if (blink_inc >= REPEATS) begin
            blink_nxt = '0;
            step_nxt  = ST_AMBER;
          end else begin
            blink_nxt = blink_inc;
            step_nxt  = ST_BLINK_ON;
          end
        end
        ST_AMBER: begin
          lb0_nxt  = pcls_pkg::B0_ALL_AMBER;
          lb1_nxt  = (lb1_r & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_AMBER;
          lb2_nxt  = (lb2_r & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_AMBER;
          strobe   = 1'b1;
          cnt_nxt  = rp_ext + pcls_pkg::CNT_W'(amber_time_r);
          step_nxt = ST_CROSS;
        end
        ST_CROSS: begin
          if (west_r) begin
            lb0_nxt = pcls_pkg::B0_EW_GREEN;
            lb1_nxt = (lb1_r & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_GREEN;
            lb2_nxt = (lb2_r & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_RED;
          end else begin
            lb0_nxt = pcls_pkg::B0_NS_GREEN;
            lb1_nxt = (lb1_r & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_RED;
            lb2_nxt = (lb2_r & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_GREEN;
          end
          strobe   = 1'b1;
          cnt_nxt  = rp_ext;
          step_nxt = ST_WALK_GO;
        end
        ST_WALK_GO: begin
          wb_nxt   = (wb & pcls_pkg::HIGH_GROUP) | pcls_pkg::WALK_GO_BIT;
          strobe   = 1'b1;
          cnt_nxt  = rp_ext + pcls_pkg::CNT_W'(walk_time_r);
          step_nxt = ST_WALK_RED;
        end
        ST_WALK_RED: begin
          wb_nxt   = (wb & pcls_pkg::HIGH_GROUP) | pcls_pkg::WALK_RED_BIT;
          strobe   = 1'b1;
          step_nxt = ST_IDLE;
          west_nxt = 1'b0;
          cnt_nxt  = rp_ext;
          if (!west_r) begin
            north_pend_nxt = 1'b0;
            // hand over to west if it was waiting
            if (west_pend_r) begin
              svc      = 1'b1;
              svc_west = 1'b1;
              svc_wait = rp_ext;
            end
          end else begin
            west_pend_nxt = 1'b0;
          end
        end
        default: begin
          step_nxt       = ST_IDLE;
          west_nxt       = 1'b0;
          north_pend_nxt = in_data.north_walk_request;
          west_pend_nxt  = in_data.west_walk_request;
          if (in_data.north_walk_request) begin
            svc      = 1'b1;
            svc_west = 1'b0;
          end else if (in_data.west_walk_request) begin
            svc      = 1'b1;
            svc_west = 1'b1;
          end
        end
      endcase
    end

    // write back the walk byte of the served road
    if (west_r) begin
      if (step_r != ST_AMBER && step_r != ST_CROSS) lb2_nxt = wb_nxt;
    end else begin
      if (step_r != ST_AMBER && step_r != ST_CROSS) lb1_nxt = wb_nxt;
    end

    svc_green = svc_west ? ((lb2_r & pcls_pkg::HIGH_GREEN) != 8'h00)
                         : ((lb0_r & pcls_pkg::NORTH_GREEN) != 8'h00);
    if (svc) begin
      blink_nxt = '0;
      west_nxt  = svc_west;
      if (svc_green) begin
        step_nxt = ST_BLINK_ON;
        cnt_nxt  = svc_wait + pcls_pkg::CNT_W'(settle_pause_r);
      end else begin
        step_nxt = ST_WALK_GO;
        cnt_nxt  = svc_wait;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_IDLE;
      west_r       <= 1'b0;
      cnt_r        <= '0;
      blink_r      <= '0;
      north_pend_r <= 1'b0;
      west_pend_r  <= 1'b0;
      lb0_r        <= pcls_pkg::LB0_RST;
      lb1_r        <= pcls_pkg::LB1_RST;
      lb2_r        <= pcls_pkg::LB2_RST;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      if (in_fire) begin
        step_r       <= step_nxt;
        west_r       <= west_nxt;
        cnt_r        <= cnt_nxt;
        blink_r      <= blink_nxt;
        north_pend_r <= north_pend_nxt;
        west_pend_r  <= west_pend_nxt;
        lb0_r        <= lb0_nxt;
        lb1_r        <= lb1_nxt;
        lb2_r        <= lb2_nxt;
        out_valid_r  <= 1'b1;
        // result payload: load on transfer only
        out_data_r.light_byte_zero <= lb0_nxt;
        out_data_r.light_byte_one  <= lb1_nxt;
        out_data_r.light_byte_two  <= lb2_nxt;
        out_data_r.refresh_strobe  <= strobe;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_half_r    <= pcls_pkg::BLINK_HALF_PERIOD_RST;
      amber_time_r    <= pcls_pkg::AMBER_TIME_RST;
      walk_time_r     <= pcls_pkg::WALK_TIME_RST;
      refresh_pause_r <= pcls_pkg::REFRESH_PAUSE_RST;
      settle_pause_r  <= pcls_pkg::SETTLE_PAUSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcls_pkg::REG_BLINK_HALF_PERIOD: blink_half_r    <= cfg_wdata;
        pcls_pkg::REG_AMBER_TIME:        amber_time_r    <= cfg_wdata;
        pcls_pkg::REG_WALK_TIME:         walk_time_r     <= cfg_wdata;
        pcls_pkg::REG_REFRESH_PAUSE:     refresh_pause_r <= cfg_wdata;
        pcls_pkg::REG_SETTLE_PAUSE:      settle_pause_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  `PCLS_ASSERT_IMP(a_blink_idle_zero, !blinking, (blink_r == '0), "blink count left set")
  `PCLS_ASSERT_IMP(a_blink_bound, 1'b1, (blink_r < REPEATS), "blink count reached the limit")
  `PCLS_ASSERT_NXT(a_wait_quiet, in_fire && cnt_busy, !out_data_r.refresh_strobe, "strobe in wait")
  `PCLS_ASSERT_IMP(a_idle_no_road, (step_r == ST_IDLE), (!west_r), "road bit set while idle")
  `PCLS_ASSERT_IMP(a_stall_blocks_input, (out_valid_r && !out_ready), (!in_ready), "input in stall")

endmodule

[sim/tb_pedestrian_crossing_light_sequencer.sv]
// Self-checking testbench for the pedestrian crossing light sequencer.
// Depends on pcls_pkg and the RTL top; a cycle-accurate predictor or a directed row checks every result transfer.
`timescale 1ns / 1ps

module tb_pedestrian_crossing_light_sequencer;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS    = 24;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_BLINK_ON  = 3'd1,
    PH_BLINK_OFF = 3'd2,
    PH_AMBER     = 3'd3,
    PH_CROSS     = 3'd4,
    PH_WALK_GO   = 3'd5,
    PH_WALK_RED  = 3'd6
  } road_step_t;

  typedef struct packed {
    logic                typed;
    pcls_pkg::in_item_t  tick;
    pcls_pkg::out_item_t want;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  pcls_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  pcls_pkg::out_item_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [pcls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pcls_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // side data that travels with the tick being offered
  logic                tick_typed = 1'b0;
  pcls_pkg::out_item_t tick_want = '0;

  // predictor state
  logic [7:0]                 shown_b0, shown_b1, shown_b2;
  logic                       road_west;
  road_step_t                 road_step;
  logic [pcls_pkg::CNT_W-1:0] hold_count;
  logic [2:0]                 blink_done;
  logic                       north_waiting, west_waiting;
  logic [pcls_pkg::CFG_W-1:0] t_half, t_amber, t_walk, t_refresh, t_settle;

  pcls_pkg::out_item_t expected_lights [$];
  dir_row_t            dir_rows [DIR_ROWS];
  int                  fail_count = 0;
  int                  cycles = 0;
  int                  burst_left = 0;
  logic [15:0]         stall_mask = '0;
  logic [5:0]          rx_slot = '0;

  pedestrian_crossing_light_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pick the first step for a road: blink if its car light is green, else walk go.
  function automatic void start_road(input logic west,
                                     input logic [pcls_pkg::CNT_W-1:0] wait_ticks);
    logic green;
    green = west ? ((shown_b2 & pcls_pkg::HIGH_GREEN) != 8'h00)
                 : ((shown_b0 & pcls_pkg::NORTH_GREEN) != 8'h00);
    road_west = west;
    blink_done = '0;
    if (green) begin
      road_step = PH_BLINK_ON;
      hold_count = wait_ticks + {1'b0, t_settle};
    end else begin
      road_step = PH_WALK_GO;
      hold_count = wait_ticks;
    end
  endfunction

  function automatic pcls_pkg::out_item_t next_lights(input pcls_pkg::in_item_t tick);
    pcls_pkg::out_item_t res;
    logic [7:0]          walk_lamps;
    logic                west, strobe, lamps_set;
    strobe = 1'b0;
    lamps_set = 1'b0;
    west = road_west;
    walk_lamps = west ? shown_b2 : shown_b1;
    if (hold_count > 17'd1) begin
      hold_count = hold_count - 17'd1;
    end else begin
      hold_count = '0;
      strobe = 1'b1;
      case (road_step)
        PH_BLINK_ON: begin
          walk_lamps = walk_lamps | pcls_pkg::WALK_BLUE_BIT;
          lamps_set = 1'b1;
          hold_count = {1'b0, t_refresh} + {1'b0, t_half};
          road_step = PH_BLINK_OFF;
        end
        PH_BLINK_OFF: begin
          walk_lamps = (walk_lamps & pcls_pkg::HIGH_GROUP) | pcls_pkg::WALK_RED_BIT;
          lamps_set = 1'b1;
          hold_count = {1'b0, t_refresh} + {1'b0, t_half};
          blink_done = blink_done + 3'd1;
          if (blink_done >= 3'(pcls_pkg::BLINK_REPEATS_DEF)) begin
            blink_done = '0;
            road_step = PH_AMBER;
          end else begin
            road_step = PH_BLINK_ON;
          end
        end
        PH_AMBER: begin
          shown_b0 = pcls_pkg::B0_ALL_AMBER;
          shown_b1 = (shown_b1 & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_AMBER;
          shown_b2 = (shown_b2 & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_AMBER;
          hold_count = {1'b0, t_refresh} + {1'b0, t_amber};
          road_step = PH_CROSS;
        end
        PH_CROSS: begin
          if (west) begin
            shown_b0 = pcls_pkg::B0_EW_GREEN;
            shown_b1 = (shown_b1 & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_GREEN;
            shown_b2 = (shown_b2 & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_RED;
          end else begin
            shown_b0 = pcls_pkg::B0_NS_GREEN;
            shown_b1 = (shown_b1 & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_RED;
            shown_b2 = (shown_b2 & pcls_pkg::LOW_GROUP) | pcls_pkg::HIGH_GREEN;
          end
          hold_count = {1'b0, t_refresh};
          road_step = PH_WALK_GO;
        end
        PH_WALK_GO: begin
          walk_lamps = (walk_lamps & pcls_pkg::HIGH_GROUP) | pcls_pkg::WALK_GO_BIT;
          lamps_set = 1'b1;
          hold_count = {1'b0, t_refresh} + {1'b0, t_walk};
          road_step = PH_WALK_RED;
        end
        PH_WALK_RED: begin
          walk_lamps = (walk_lamps & pcls_pkg::HIGH_GROUP) | pcls_pkg::WALK_RED_BIT;
          lamps_set = 1'b1;
          road_step = PH_IDLE;
          road_west = 1'b0;
          hold_count = {1'b0, t_refresh};
          if (west) begin
            west_waiting = 1'b0;
          end else begin
            north_waiting = 1'b0;
            // west latched with north: serve it right after
            if (west_waiting) start_road(1'b1, {1'b0, t_refresh});
          end
        end
        default: begin
          // idle and expired: latch both buttons
          strobe = 1'b0;
          road_step = PH_IDLE;
          road_west = 1'b0;
          north_waiting = tick.north_walk_request;
          west_waiting = tick.west_walk_request;
          if (north_waiting) start_road(1'b0, '0);
          else if (west_waiting) start_road(1'b1, '0);
        end
      endcase
      if (lamps_set) begin
        if (west) shown_b2 = walk_lamps;
        else shown_b1 = walk_lamps;
      end
    end
    res.light_byte_zero = shown_b0;
    res.light_byte_one  = shown_b1;
    res.light_byte_two  = shown_b2;
    res.refresh_strobe  = strobe;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Receiver: stall on a 16-slot mask, rerolled each time the 6-bit slot counter wraps; slot 0 always ready.
  always @(posedge clk) begin
    if (rx_slot == 6'd63) begin
      stall_mask <= ($urandom_range(0, 3) == 0) ? 16'h0000 : (16'($urandom()) & 16'hFFFE);
    end
    rx_slot <= rx_slot + 6'd1;
    out_ready <= !stall_mask[rx_slot[3:0]];
  end

  // Predictor and checker, sampled at the same edge the block sees.
  always @(posedge clk) begin
    pcls_pkg::out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end else if (!rst_n) begin
      shown_b0 = pcls_pkg::LB0_RST;
      shown_b1 = pcls_pkg::LB1_RST;
      shown_b2 = pcls_pkg::LB2_RST;
      road_west = 1'b0;
      road_step = PH_IDLE;
      hold_count = '0;
      blink_done = '0;
      north_waiting = 1'b0;
      west_waiting = 1'b0;
      t_half = pcls_pkg::BLINK_HALF_PERIOD_RST;
      t_amber = pcls_pkg::AMBER_TIME_RST;
      t_walk = pcls_pkg::WALK_TIME_RST;
      t_refresh = pcls_pkg::REFRESH_PAUSE_RST;
      t_settle = pcls_pkg::SETTLE_PAUSE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcls_pkg::REG_BLINK_HALF_PERIOD: t_half = cfg_wdata;
          pcls_pkg::REG_AMBER_TIME:        t_amber = cfg_wdata;
          pcls_pkg::REG_WALK_TIME:         t_walk = cfg_wdata;
          pcls_pkg::REG_REFRESH_PAUSE:     t_refresh = cfg_wdata;
          pcls_pkg::REG_SETTLE_PAUSE:      t_settle = cfg_wdata;
          default: ;
        endcase
      end
      // check the result transfer before queueing this edge's tick
      if (out_valid && out_ready) begin
        if (expected_lights.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_lights.pop_front();
          check_field("light_byte_zero", want.light_byte_zero, out_data.light_byte_zero);
          check_field("light_byte_one", want.light_byte_one, out_data.light_byte_one);
          check_field("light_byte_two", want.light_byte_two, out_data.light_byte_two);
          check_field("refresh_strobe", {7'd0, want.refresh_strobe},
                      {7'd0, out_data.refresh_strobe});
        end
      end
      if (in_valid && in_ready) begin
        want = next_lights(in_data);
        expected_lights.push_back(tick_typed ? tick_want : want);
      end
    end
  end

  task automatic cfg_write(input logic [pcls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcls_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_timing(input logic [pcls_pkg::CFG_W-1:0] half,
                              input logic [pcls_pkg::CFG_W-1:0] amber,
                              input logic [pcls_pkg::CFG_W-1:0] walk,
                              input logic [pcls_pkg::CFG_W-1:0] refresh,
                              input logic [pcls_pkg::CFG_W-1:0] settle);
    cfg_write(pcls_pkg::REG_BLINK_HALF_PERIOD, half);
    cfg_write(pcls_pkg::REG_AMBER_TIME, amber);
    cfg_write(pcls_pkg::REG_WALK_TIME, walk);
    cfg_write(pcls_pkg::REG_REFRESH_PAUSE, refresh);
    cfg_write(pcls_pkg::REG_SETTLE_PAUSE, settle);
    cfg_we <= 1'b0;
  endtask

  // Offer one tick; returns at the edge of its transfer with valid still high.
  task automatic send_tick(input pcls_pkg::in_item_t tick, input logic typed,
                           input pcls_pkg::out_item_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= tick;
    tick_typed <= typed;
    tick_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_lights.size() != 0);
  endtask

  initial begin
    pcls_pkg::in_item_t tick;
    int                 p, n;
    // reset, a walk-only request on the red west road, then both buttons at once
    dir_rows[0]  = {1'b1, 2'b00, 8'h84, 8'h30, 8'h90, 1'b0};
    dir_rows[1]  = {1'b1, 2'b01, 8'h84, 8'h30, 8'h90, 1'b0};
    dir_rows[2]  = {1'b1, 2'b00, 8'h84, 8'h30, 8'h88, 1'b1};
    dir_rows[3]  = {1'b1, 2'b00, 8'h84, 8'h30, 8'h90, 1'b1};
    dir_rows[4]  = {1'b1, 2'b00, 8'h84, 8'h30, 8'h90, 1'b0};
    dir_rows[5]  = {1'b1, 2'b11, 8'h84, 8'h30, 8'h90, 1'b0};
    dir_rows[6]  = {1'b1, 2'b00, 8'h84, 8'h34, 8'h90, 1'b1};
    dir_rows[7]  = {1'b1, 2'b00, 8'h84, 8'h30, 8'h90, 1'b1};
    // presses in the middle of a sequence must be dropped
    dir_rows[8]  = {1'b0, 2'b11, 25'd0};
    dir_rows[9]  = {1'b0, 2'b00, 25'd0};
    dir_rows[10] = {1'b0, 2'b10, 25'd0};
    dir_rows[11] = {1'b0, 2'b01, 25'd0};
    dir_rows[12] = {1'b0, 2'b00, 25'd0};
    dir_rows[13] = {1'b0, 2'b00, 25'd0};
    dir_rows[14] = {1'b0, 2'b11, 25'd0};
    dir_rows[15] = {1'b0, 2'b00, 25'd0};
    dir_rows[16] = {1'b0, 2'b00, 25'd0};
    dir_rows[17] = {1'b0, 2'b00, 25'd0};
    dir_rows[18] = {1'b0, 2'b00, 25'd0};
    dir_rows[19] = {1'b0, 2'b10, 25'd0};
    dir_rows[20] = {1'b0, 2'b00, 25'd0};
    dir_rows[21] = {1'b0, 2'b01, 25'd0};
    dir_rows[22] = {1'b0, 2'b00, 25'd0};
    dir_rows[23] = {1'b0, 2'b00, 25'd0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // shortest legal timing: every wait collapses to one tick
    write_timing(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
    for (n = 0; n < DIR_ROWS; n++) begin
      send_tick(dir_rows[n].tick, dir_rows[n].typed, dir_rows[n].want);
    end
    drain_results();

    for (p = 0; p < 7; p++) begin
      if (p == 5) begin
        // zero where one is the floor: must act as a single tick
        write_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      end else if (p == 6) begin
        write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else begin
        write_timing(16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 6)), 16'($urandom_range(0, 2)),
                     16'($urandom_range(0, 4)));
      end
      for (n = 0; n < ((p < 5) ? 70 : 30); n++) begin
        tick.north_walk_request = 1'($urandom_range(0, 1));
        tick.west_walk_request = 1'($urandom_range(0, 1));
        send_tick(tick, 1'b0, '0);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && expected_lights.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
